FILE: rtl/core/fgntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgntc_pkg
// Shared types, codes and arithmetic helpers of the terrain noise pipeline.
// ----------------------------------------------------------------------------
package fgntc_pkg;

    localparam int TABLE_AW = 12;
    localparam int TABLE_DW = 32;
    localparam int NOISE_W  = 20;
    localparam int LEVEL_N  = 7;

    // request kinds on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_BASE_FREQ      = 3'd0;
    localparam logic [2:0] REG_LEVEL_DEEP     = 3'd1;
    localparam logic [2:0] REG_LEVEL_SHALLOW  = 3'd2;
    localparam logic [2:0] REG_LEVEL_BEACH    = 3'd3;
    localparam logic [2:0] REG_LEVEL_GRASS    = 3'd4;
    localparam logic [2:0] REG_LEVEL_FOREST   = 3'd5;
    localparam logic [2:0] REG_LEVEL_ROCK     = 3'd6;
    localparam logic [2:0] REG_LEVEL_MOUNTAIN = 3'd7;

    typedef logic [7:0] chan_t;
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgb_t;

    function automatic rgb_t palette(input logic [2:0] c);
        rgb_t p;
        case (c)
            3'd0:    p = '{blue: 8'd150, green: 8'd0,   red: 8'd0};
            3'd1:    p = '{blue: 8'd200, green: 8'd100, red: 8'd0};
            3'd2:    p = '{blue: 8'd130, green: 8'd220, red: 8'd240};
            3'd3:    p = '{blue: 8'd34,  green: 8'd139, red: 8'd34};
            3'd4:    p = '{blue: 8'd12,  green: 8'd105, red: 8'd13};
            3'd5:    p = '{blue: 8'd100, green: 8'd100, red: 8'd100};
            3'd6:    p = '{blue: 8'd152, green: 8'd153, red: 8'd151};
            default: p = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        endcase
        return p;
    endfunction

    // remainder after a reciprocal estimate q that is at most one low
    function automatic logic [19:0] mod_fix(input logic [18:0] v, input logic [19:0] q,
                                            input logic [8:0] m);
        logic [28:0] qm;
        logic [19:0] r;
        qm = 29'(q) * 29'(m);
        r  = 20'({1'b0, v}) - qm[19:0];
        if (r >= 20'(m)) begin
            r = r - 20'(m);
        end
        return r;
    endfunction

    // quintic fade 6t^5-15t^4+10t^3, split over three stages
    function automatic logic [15:0] fade_sq(input logic [15:0] t);
        logic [31:0] p;
        p = 32'(t) * 32'(t);
        return p[31:16];
    endfunction

    function automatic logic signed [37:0] fade_lin(input logic [15:0] t);
        logic signed [21:0] d;
        d = 22'sd6 * $signed({6'b0, t}) - 22'sd983040;
        return 38'(d) * 38'($signed({1'b0, t}));
    endfunction

    function automatic logic [15:0] fade_cube(input logic [15:0] t2, input logic [15:0] t);
        logic [31:0] p;
        p = 32'(t2) * 32'(t);
        return p[31:16];
    endfunction

    function automatic logic signed [21:0] fade_inner(input logic signed [37:0] ip);
        return 22'(ip >>> 16) + 22'sd655360;
    endfunction

    function automatic logic signed [17:0] fade_out(input logic [15:0] t3,
                                                    input logic signed [21:0] inner);
        logic signed [39:0] p;
        p = 40'($signed({1'b0, t3})) * 40'(inner);
        return 18'(p >>> 16);
    endfunction

    // gradient dot offset, entry holds cos low and sin high
    function automatic logic signed [19:0] corner_dot(input logic [31:0] e,
                                                      input logic signed [16:0] ox,
                                                      input logic signed [16:0] oy);
        logic signed [33:0] s;
        s = 34'($signed(e[15:0])) * 34'(ox) + 34'($signed(e[31:16])) * 34'(oy);
        return 20'(s >>> 14);
    endfunction

    function automatic logic signed [21:0] blend_a(input logic signed [17:0] w,
                                                   input logic signed [19:0] a,
                                                   input logic signed [19:0] b);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = 21'(b) - 21'(a);
        p = 39'(w) * 39'(d);
        return 22'(a) + 22'(p >>> 16);
    endfunction

    function automatic logic signed [23:0] blend_b(input logic signed [17:0] w,
                                                   input logic signed [21:0] a,
                                                   input logic signed [21:0] b);
        logic signed [22:0] d;
        logic signed [40:0] p;
        d = 23'(b) - 23'(a);
        p = 41'(w) * 41'(d);
        return 24'(a) + 24'(p >>> 16);
    endfunction

endpackage

FILE: rtl/core/fgntc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgntc_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module fgntc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fractal_gradient_noise_terrain_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_terrain_colour
// Throughput: one request per cycle, loads and samples alike, unless a result
//   waits at the output; every octave has its own lane with four table copies,
//   one per cell corner.
// Load requests write all table copies and produce no result.
// Reset (aresetn low, synchronous) empties the pipe, restores levels and base frequency;
//   the gradient table keeps its contents and must be loaded before sampling.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_terrain_colour
    import fgntc_pkg::*;
#(
    parameter int GRID_W       = 64,
    parameter int GRID_H       = 64,
    parameter int OCTAVE_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: entry_index[11:0], gradient_cos[27:12], gradient_sin[43:28],
    //          pixel_x[55:44], pixel_y[67:56], zero pad[71:68]
    input  logic [71:0] s_tdata,
    // s_tuser: opcode[0]
    input  logic [0:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: noise_value[19:0], red[27:20], green[35:28], blue[43:36],
    //          zero pad[47:44]
    output logic [47:0] m_tdata,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    // Stage map (all lanes in lockstep, one valid bit per stage):
    //  0 capture pixel        1 coordinate multiply   2 reciprocal, fade step 1
    //  3 cell index, fade 2   4 table read, fade 3    5 corner dot products
    //  6 blend along x        7 blend along y          8 octave sum
    //  9 remap + saturate     out: colour pick, output register
    localparam int NSTAGE = 10;

    localparam int IXW = $clog2(GRID_W);
    localparam int IYW = $clog2(GRID_H);
    localparam int MXI = GRID_W - 1;
    localparam int MYI = GRID_H - 1;
    localparam logic [8:0]  MX = 9'(MXI);
    localparam logic [8:0]  MY = 9'(MYI);
    // floor(2^32 / m): quotient estimate is at most one low for 19-bit values
    localparam logic [32:0] RECIP_X = 33'((longint'(1) << 32) / longint'(MXI));
    localparam logic [32:0] RECIP_Y = 33'((longint'(1) << 32) / longint'(MYI));

    // ---------------- configuration ----------------
    logic [23:0] base_freq_reg;
    logic [15:0] level_reg [LEVEL_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_freq_reg <= 24'd83886;
            level_reg[0]  <= 16'd14746;
            level_reg[1]  <= 16'd26214;
            level_reg[2]  <= 16'd28180;
            level_reg[3]  <= 16'd40632;
            level_reg[4]  <= 16'd50463;
            level_reg[5]  <= 16'd55706;
            level_reg[6]  <= 16'd60293;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_FREQ: begin
                    base_freq_reg <= cfg_wdata;
                end
                default: begin
                    level_reg[3'(cfg_index - REG_LEVEL_DEEP)] <= cfg_wdata[15:0];
                end
            endcase
        end
    end

    // ---------------- flow control ----------------
    // The whole pipe moves together; it only halts while a result waits.
    logic              adv;
    logic              s_fire;
    logic              load_we;
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign s_fire   = s_tvalid && adv;
    assign load_we  = s_fire && (s_tuser[0] == OP_LOAD);
    assign vld_next = {vld_reg[NSTAGE-2:0], s_fire && (s_tuser[0] == OP_SAMPLE)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[NSTAGE-1];
        end
    end

    // stage 0: pixel capture
    logic [11:0] px0_reg;
    logic [11:0] py0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            px0_reg <= s_tdata[55:44];
            py0_reg <= s_tdata[67:56];
        end
    end

    // ---------------- octave lanes ----------------
    logic signed [31:0] lane_w [OCTAVE_COUNT];

    for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_lane
        logic [30:0]              step_w;
        logic [42:0]              c_reg   [2];
        logic [51:0]              qp_reg  [2];
        logic [18:0]              ip2_reg [2];
        logic [15:0]              t2_reg  [2];
        logic [15:0]              t3_reg  [2];
        logic [15:0]              t4_reg  [2];
        logic [15:0]              sq_reg  [2];
        logic signed [37:0]       lin_reg [2];
        logic [15:0]              cube_reg[2];
        logic signed [21:0]       inner_reg[2];
        logic signed [17:0]       w4_reg  [2];
        logic [IXW-1:0]           ix_reg;
        logic [IYW-1:0]           iy_reg;
        logic [IXW-1:0]           ixr_w;
        logic [IYW-1:0]           iyr_w;
        logic [TABLE_AW-1:0]      addr_w  [4];
        logic [TABLE_DW-1:0]      rd_w    [4];
        logic signed [19:0]       dot_reg [4];
        logic signed [17:0]       wx5_reg;
        logic signed [17:0]       wy5_reg;
        logic signed [17:0]       wy6_reg;
        logic signed [21:0]       top_reg;
        logic signed [21:0]       bot_reg;
        logic signed [23:0]       n_reg;

        assign step_w = 31'(base_freq_reg) << o;

        // right and lower neighbors wrap at the last usable cell
        assign ixr_w = (32'(ix_reg) == MXI - 1) ? '0 : IXW'(32'(ix_reg) + 32'd1);
        assign iyr_w = (32'(iy_reg) == MYI - 1) ? '0 : IYW'(32'(iy_reg) + 32'd1);

        // corners: top-left, top-right, bottom-left, bottom-right
        assign addr_w[0] = TABLE_AW'(32'(iy_reg) * 32'(GRID_W) + 32'(ix_reg));
        assign addr_w[1] = TABLE_AW'(32'(iy_reg) * 32'(GRID_W) + 32'(ixr_w));
        assign addr_w[2] = TABLE_AW'(32'(iyr_w) * 32'(GRID_W) + 32'(ix_reg));
        assign addr_w[3] = TABLE_AW'(32'(iyr_w) * 32'(GRID_W) + 32'(ixr_w));

        for (genvar k = 0; k < 4; k++) begin : g_copy
            fgntc_ram #(
                .WIDTH (TABLE_DW),
                .DEPTH (1 << TABLE_AW)
            ) u_ram (
                .aclk  (aclk),
                .we    (load_we),
                .waddr (s_tdata[11:0]),
                .wdata (s_tdata[43:12]),
                .re    (adv),
                .raddr (addr_w[k]),
                .rdata (rd_w[k])
            );
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                // stage 1
                c_reg[0] <= 43'(px0_reg) * 43'(step_w);
                c_reg[1] <= 43'(py0_reg) * 43'(step_w);
                for (int a = 0; a < 2; a++) begin
                    // stage 2
                    qp_reg[a]  <= 52'(c_reg[a][42:24]) * 52'((a == 0) ? RECIP_X : RECIP_Y);
                    ip2_reg[a] <= c_reg[a][42:24];
                    t2_reg[a]  <= c_reg[a][23:8];
                    sq_reg[a]  <= fade_sq(c_reg[a][23:8]);
                    lin_reg[a] <= fade_lin(c_reg[a][23:8]);
                    // stage 3
                    t3_reg[a]    <= t2_reg[a];
                    cube_reg[a]  <= fade_cube(sq_reg[a], t2_reg[a]);
                    inner_reg[a] <= fade_inner(lin_reg[a]);
                    // stage 4
                    t4_reg[a] <= t3_reg[a];
                    w4_reg[a] <= fade_out(cube_reg[a], inner_reg[a]);
                end
                ix_reg <= IXW'(mod_fix(ip2_reg[0], qp_reg[0][51:32], MX));
                iy_reg <= IYW'(mod_fix(ip2_reg[1], qp_reg[1][51:32], MY));
                // stage 5: offsets t and t-1
                dot_reg[0] <= corner_dot(rd_w[0], $signed({1'b0, t4_reg[0]}),
                                         $signed({1'b0, t4_reg[1]}));
                dot_reg[1] <= corner_dot(rd_w[1], $signed({1'b1, t4_reg[0]}),
                                         $signed({1'b0, t4_reg[1]}));
                dot_reg[2] <= corner_dot(rd_w[2], $signed({1'b0, t4_reg[0]}),
                                         $signed({1'b1, t4_reg[1]}));
                dot_reg[3] <= corner_dot(rd_w[3], $signed({1'b1, t4_reg[0]}),
                                         $signed({1'b1, t4_reg[1]}));
                wx5_reg <= w4_reg[0];
                wy5_reg <= w4_reg[1];
                // stage 6
                top_reg <= blend_a(wx5_reg, dot_reg[0], dot_reg[1]);
                bot_reg <= blend_a(wx5_reg, dot_reg[2], dot_reg[3]);
                wy6_reg <= wy5_reg;
                // stage 7
                n_reg <= blend_b(wy6_reg, top_reg, bot_reg);
            end
        end

        // octave weight 2^(1-o), floored
        if (o == 0) begin : g_w_first
            assign lane_w[o] = 32'(n_reg) <<< 1;
        end else begin : g_w_rest
            assign lane_w[o] = 32'(n_reg) >>> (o - 1);
        end
    end

    // ---------------- sum, remap, colour ----------------
    logic signed [31:0]        sum_w;
    logic signed [31:0]        sum_reg;
    logic signed [32:0]        half_w;
    logic signed [NOISE_W-1:0] nv_next;
    logic signed [NOISE_W-1:0] nv_reg;
    logic [2:0]                colour_w;
    rgb_t                      rgb_w;

    always_comb begin
        sum_w = '0;
        for (int i = 0; i < OCTAVE_COUNT; i++) begin
            sum_w = sum_w + lane_w[i];
        end
    end

    // (s + 1.0) / 2, floored, then pinned to the Q3.16 range
    assign half_w = (33'(sum_reg) + 33'sd65536) >>> 1;

    always_comb begin
        if (half_w > 33'sd524287) begin
            nv_next = 20'sd524287;
        end else if (half_w < -33'sd524288) begin
            nv_next = -20'sd524288;
        end else begin
            nv_next = NOISE_W'(half_w);
        end
    end

    // first level the noise stays below picks the colour; negative is deep water
    always_comb begin
        colour_w = 3'd7;
        for (int i = LEVEL_N - 1; i >= 0; i--) begin
            if (nv_reg < $signed({4'b0, level_reg[i]})) begin
                colour_w = 3'(i);
            end
        end
    end

    assign rgb_w = palette(colour_w);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg     <= sum_w;
            nv_reg      <= nv_next;
            m_tdata_reg <= {4'b0, rgb_w.blue, rgb_w.green, rgb_w.red, nv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipe valid bits moved during an output stall");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_LOAD)) |=> !vld_reg[0])
        else $error("load request entered the result pipe");

    a_negative_is_deep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[NOISE_W-1]) |-> (m_tdata[43:20] == palette(3'd0)))
        else $error("negative noise did not map to deep water");

endmodule
